// ===== hw/rtl/midpoint_insertion_cache_defines.svh =====
// ----------------------------------------------------------------------------
// Midpoint insertion cache assertion macros
// Shared assertion forms, clocked on clk and masked while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_INSERTION_CACHE_DEFINES_SVH
`define MIDPOINT_INSERTION_CACHE_DEFINES_SVH

// same-cycle implication
`define MIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mic_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint insertion cache package
// Cell command type, register indexes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mic_pkg;

  localparam int POS_W    = 10;   // cell position, enough for 1024 cells
  localparam int TOT_W    = 32;
  localparam int OUT_W    = 40;   // hit + total_hits, padded to bytes
  localparam int PCT_FULL = 100;

  localparam logic [2:0] REG_CAPACITY      = 3'd0;
  localparam logic [2:0] REG_HOT_CAPACITY  = 3'd1;
  localparam logic [2:0] REG_PROMOTE_HITS  = 3'd2;
  localparam logic [2:0] REG_DECAY_PERIOD  = 3'd3;
  localparam logic [2:0] REG_DECAY_PERCENT = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_HITS,    // cell at pos takes bus hits
    CELL_INSERT,  // cell at pos takes bus, pos+1..last take left neighbor
    CELL_MOVE     // pos..last-1 take right neighbor, cell at last takes bus
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] last;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/midpoint_insertion_cache.sv =====
// Sequence: an accepted request passes through lookup, an optional demote, count
//   and an optional decay pass over the hot list before its result is registered.
// Throughput: one request at a time, set by the lookup / reorder / count sequencer;
//   in_tready is high only in idle, after the previous result is loaded for output;
//   decay walks the hot list through a keep-percent multiply and a reciprocal multiply.
// Reset: synchronous active-low rst_n empties both zones, clears counters
//   and loads the default configuration; cell contents are not cleared.
// ----------------------------------------------------------------------------
// Midpoint insertion cache
// Hot/cold list cache held in a chain of cells, with promotion and decay.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_insertion_cache_defines.svh"

module midpoint_insertion_cache #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 12,
  parameter int HIT_BITS    = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [((KEY_BITS+7)/8)*8-1:0]  in_tdata,   // [KEY_BITS-1:0] key
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [mic_pkg::OUT_W-1:0]      out_tdata,  // [0] hit, [32:1] total_hits
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [2:0]                     cfg_index,
  input  wire  [15:0]                    cfg_data
);
  import mic_pkg::*;

  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int EW  = ((CW > 7) ? CW : 7) + 1;
  localparam int CMPW = (HIT_BITS > 16) ? HIT_BITS : 16;
  localparam int PW  = HIT_BITS + 7;          // hits * keep percent
  localparam int RS  = PW + 7;                // reciprocal shift
  localparam int KW  = PW + 1;                // reciprocal width
  localparam int MW  = PW + KW;
  localparam logic [63:0] RK = ((64'd1 << RS) + 64'(PCT_FULL - 1)) / 64'(PCT_FULL);
  localparam logic [HIT_BITS-1:0] HMAX = {HIT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DEMOTE, S_COUNT, S_DEC_CHK, S_DEC_MUL, S_DEC_APPLY, S_DONE
  } state_t;

  // configuration
  logic [6:0]  cap_r;
  logic [5:0]  hcap_r;
  logic [15:0] prom_r, per_r;
  logic [6:0]  pct_r;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       hot_r, hot_nxt, cold_r, cold_nxt, idx_r, idx_nxt;
  logic [15:0]         ac_r, ac_nxt;
  logic [TOT_W-1:0]    tot_r, tot_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic                hit_r, hit_nxt;
  logic [PW-1:0]       mul1_r, mul1_nxt;
  logic [MW-1:0]       mul2_r, mul2_nxt;
  logic                out_valid_r, out_hit_r;
  logic [TOT_W-1:0]    out_tot_r;

  // cell chain
  cell_ctl_t           ctl;
  logic [KEY_BITS-1:0] bus_key;
  logic [HIT_BITS-1:0] bus_hits;
  logic [KEY_BITS-1:0] cell_key  [MAX_ENTRIES];
  logic [HIT_BITS-1:0] cell_hits [MAX_ENTRIES];

  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    mic_cell #(.IDX(j), .KEY_BITS(KEY_BITS), .HIT_BITS(HIT_BITS)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .bus_key    (bus_key),
      .bus_hits   (bus_hits),
      .left_key   (cell_key[(j == 0) ? 0 : j - 1]),
      .left_hits  (cell_hits[(j == 0) ? 0 : j - 1]),
      .right_key  (cell_key[(j == MAX_ENTRIES - 1) ? j : j + 1]),
      .right_hits (cell_hits[(j == MAX_ENTRIES - 1) ? j : j + 1]),
      .cur_key    (cell_key[j]),
      .cur_hits   (cell_hits[j])
    );
  end

  // Cold count after eviction: drop cold tail while occupancy reaches capacity.
  function automatic logic [CW-1:0] evict(input logic [CW-1:0] h, input logic [CW-1:0] c);
    logic [EW-1:0] cap_w;
    logic [EW-1:0] sum;
    cap_w = (EW'(cap_r) > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : EW'(cap_r);
    sum   = EW'(h) + EW'(c);
    if (c != '0 && sum >= cap_w) begin
      return (cap_w > EW'(h)) ? CW'(cap_w - EW'(h) - EW'(1)) : '0;
    end
    return c;
  endfunction

  logic [CW-1:0]       total;
  logic                found;
  logic [IW-1:0]       fidx;
  logic [HIT_BITS-1:0] h_inc;
  logic [CW-1:0]       cold_a, tot_a;
  logic [6:0]          pct_c, keep;
  logic [HIT_BITS-1:0] dq;
  logic [IW-1:0]       demote_pos, walk_pos;

  assign total      = hot_r + cold_r;
  assign pct_c      = (pct_r > 7'(PCT_FULL)) ? 7'(PCT_FULL) : pct_r;
  assign keep       = 7'(PCT_FULL) - pct_c;
  assign dq         = mul2_r[RS +: HIT_BITS];
  assign demote_pos = IW'(hot_r - CW'(1));
  assign walk_pos   = idx_r[IW-1:0];

  // first matching live cell
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
      if (cell_key[j] == key_r && CW'(j) < total) begin
        found = 1'b1;
        fidx  = IW'(j);
      end
    end
  end

  assign h_inc  = (cell_hits[fidx] == HMAX) ? HMAX : cell_hits[fidx] + HIT_BITS'(1);
  // a full store with cold entries drops its cold tail before a miss insert
  assign cold_a = (total == CW'(MAX_ENTRIES) && cold_r != '0) ? cold_r - CW'(1) : cold_r;
  assign tot_a  = hot_r + cold_a;

  always_comb begin
    state_nxt = state_r;
    hot_nxt   = hot_r;
    cold_nxt  = cold_r;
    idx_nxt   = idx_r;
    ac_nxt    = ac_r;
    tot_nxt   = tot_r;
    hit_nxt   = hit_r;
    mul1_nxt  = mul1_r;
    mul2_nxt  = mul2_r;
    ctl       = '{op: CELL_HOLD, pos: '0, last: '0};
    bus_key   = key_r;
    bus_hits  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        hit_nxt   = found;
        state_nxt = S_COUNT;
        if (found) begin
          if (tot_r != '1) tot_nxt = tot_r + TOT_W'(1);
          bus_hits = h_inc;
          if (CW'(fidx) >= hot_r && CMPW'(h_inc) >= CMPW'(prom_r)) begin
            // promote: move to hot head
            ctl      = '{op: CELL_INSERT, pos: '0, last: POS_W'(fidx)};
            hot_nxt  = hot_r + CW'(1);
            cold_nxt = cold_r - CW'(1);
            if (EW'(hot_r + CW'(1)) >= EW'(hcap_r)) state_nxt = S_DEMOTE;
          end else begin
            ctl = '{op: CELL_HITS, pos: POS_W'(fidx), last: '0};
          end
        end else begin
          cold_nxt = cold_a;
          if (tot_a < CW'(MAX_ENTRIES)) begin
            // insert at cold head
            ctl      = '{op: CELL_INSERT, pos: POS_W'(hot_r), last: POS_W'(tot_a)};
            cold_nxt = evict(hot_r, cold_a + CW'(1));
          end
        end
      end
      S_DEMOTE: begin
        // hot tail to cold tail
        bus_key   = cell_key[demote_pos];
        bus_hits  = cell_hits[demote_pos];
        ctl       = '{op: CELL_MOVE, pos: POS_W'(demote_pos), last: POS_W'(total - CW'(1))};
        hot_nxt   = hot_r - CW'(1);
        cold_nxt  = evict(hot_r - CW'(1), cold_r + CW'(1));
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        ac_nxt    = ac_r + 16'd1;
        state_nxt = S_DONE;
        if (ac_r + 16'd1 >= per_r) begin
          ac_nxt    = '0;
          idx_nxt   = '0;
          state_nxt = S_DEC_CHK;
        end
      end
      S_DEC_CHK: begin
        if (idx_r >= hot_r) begin
          state_nxt = S_DONE;
        end else begin
          mul1_nxt  = PW'(cell_hits[walk_pos]) * PW'(keep);
          state_nxt = S_DEC_MUL;
        end
      end
      S_DEC_MUL: begin
        // divide by 100 through the scaled reciprocal
        mul2_nxt  = MW'(mul1_r) * MW'(RK[KW-1:0]);
        state_nxt = S_DEC_APPLY;
      end
      S_DEC_APPLY: begin
        bus_key   = cell_key[walk_pos];
        bus_hits  = dq;
        state_nxt = S_DEC_CHK;
        if (CMPW'(dq) < CMPW'(prom_r)) begin
          // demote; the next hot entry slides into this slot
          ctl      = '{op: CELL_MOVE, pos: POS_W'(walk_pos), last: POS_W'(total - CW'(1))};
          hot_nxt  = hot_r - CW'(1);
          cold_nxt = evict(hot_r - CW'(1), cold_r + CW'(1));
        end else begin
          ctl     = '{op: CELL_HITS, pos: POS_W'(walk_pos), last: '0};
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hot_r       <= '0;
      cold_r      <= '0;
      idx_r       <= '0;
      ac_r        <= '0;
      tot_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
      out_tot_r   <= '0;
      cap_r       <= 7'd64;
      hcap_r      <= 6'd16;
      prom_r      <= 16'd2;
      per_r       <= 16'd1000;
      pct_r       <= 7'd50;
    end else begin
      state_r <= state_nxt;
      hot_r   <= hot_nxt;
      cold_r  <= cold_nxt;
      idx_r   <= idx_nxt;
      ac_r    <= ac_nxt;
      tot_r   <= tot_nxt;
      hit_r   <= hit_nxt;
      // hold the result until taken, then load the next one
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_hit_r   <= hit_r;
        out_tot_r   <= tot_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_CAPACITY:      cap_r  <= cfg_data[6:0];
          REG_HOT_CAPACITY:  hcap_r <= cfg_data[5:0];
          REG_PROMOTE_HITS:  prom_r <= cfg_data;
          REG_DECAY_PERIOD:  per_r  <= cfg_data;
          REG_DECAY_PERCENT: pct_r  <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) key_r <= in_tdata[KEY_BITS-1:0];
    mul1_r <= mul1_nxt;
    mul2_r <= mul2_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - TOT_W - 1){1'b0}}, out_tot_r, out_hit_r};

  `MIC_ASSERT_IMP(a_occupancy, 1'b1, (EW'(hot_r) + EW'(cold_r)) <= EW'(MAX_ENTRIES), "occupancy exceeds store")
  `MIC_ASSERT_NXT(a_accept_look, in_tvalid && in_tready, state_r == S_LOOK, "accepted request not looked up")
  `MIC_ASSERT_NXT(a_miss_total, state_r == S_LOOK && !found, $stable(tot_r), "hit total moved on a miss")

endmodule

`default_nettype wire

// ===== hw/rtl/mic_cell.sv =====
// ----------------------------------------------------------------------------
// Midpoint insertion cache cell
// One list slot: key and hit count, loaded from a neighbor or the bus.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_cell #(
  parameter int IDX      = 0,
  parameter int KEY_BITS = 12,
  parameter int HIT_BITS = 16
) (
  input  wire                     clk,
  input  wire mic_pkg::cell_ctl_t ctl,
  input  wire  [KEY_BITS-1:0]     bus_key,
  input  wire  [HIT_BITS-1:0]     bus_hits,
  input  wire  [KEY_BITS-1:0]     left_key,
  input  wire  [HIT_BITS-1:0]     left_hits,
  input  wire  [KEY_BITS-1:0]     right_key,
  input  wire  [HIT_BITS-1:0]     right_hits,
  output logic [KEY_BITS-1:0]     cur_key,
  output logic [HIT_BITS-1:0]     cur_hits
);
  import mic_pkg::*;

  localparam logic [POS_W-1:0] ME = POS_W'(IDX);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [HIT_BITS-1:0] hits_r, hits_nxt;

  always_comb begin
    key_nxt  = key_r;
    hits_nxt = hits_r;
    case (ctl.op)
      CELL_HITS: begin
        if (ME == ctl.pos) hits_nxt = bus_hits;
      end
      CELL_INSERT: begin
        if (ME == ctl.pos) begin
          key_nxt  = bus_key;
          hits_nxt = bus_hits;
        end else if (ME > ctl.pos && ME <= ctl.last) begin
          key_nxt  = left_key;
          hits_nxt = left_hits;
        end
      end
      CELL_MOVE: begin
        if (ME == ctl.last) begin
          key_nxt  = bus_key;
          hits_nxt = bus_hits;
        end else if (ME >= ctl.pos && ME < ctl.last) begin
          key_nxt  = right_key;
          hits_nxt = right_hits;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    hits_r <= hits_nxt;
  end

  assign cur_key  = key_r;
  assign cur_hits = hits_r;

endmodule

`default_nettype wire

// ===== tb/midpoint_insertion_cache_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Midpoint insertion cache testbench
// Streams access keys through the cache under random handshake gaps, keeps
// its own hot/cold list model and checks hit and running hit total per request.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_insertion_cache_tb;
  import mic_pkg::*;

  localparam int SLOTS     = 64;
  localparam int HIT_LIMIT = 65535;

  typedef struct packed {
    logic        hit;
    logic [31:0] total_hits;
  } access_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [11:0] key
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // [0] hit, [32:1] total_hits
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  midpoint_insertion_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Cache image: slots 0..hot_n-1 hot head to tail, then cold head to tail.
  int unsigned    cap_r, hot_cap_r, promote_r, period_r, pct_r;
  logic [11:0]    slot_key  [SLOTS];
  int unsigned    slot_hits [SLOTS];
  int unsigned    hot_n, cold_n, access_n;
  logic [31:0]    hit_sum;

  access_result_t expected_results[$];
  int             errors;
  int             mismatches;
  longint         cycle_count;
  bit             quiet_send;    // sender skips its random idle gaps while set
  bit             quiet_recv;    // receiver never stalls while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drop slot pos, closing the gap.
  function automatic void slot_drop(int unsigned pos);
    int unsigned n;
    n = hot_n + cold_n;
    for (int unsigned j = pos; j + 1 < n; j++) begin
      slot_key[j]  = slot_key[j+1];
      slot_hits[j] = slot_hits[j+1];
    end
  endfunction

  // Open a gap at pos and fill it.
  function automatic void slot_put(int unsigned pos, logic [11:0] k, int unsigned h);
    int unsigned n;
    n = hot_n + cold_n;
    if (n >= SLOTS) return;
    for (int j = int'(n); j > int'(pos); j--) begin
      slot_key[j]  = slot_key[j-1];
      slot_hits[j] = slot_hits[j-1];
    end
    slot_key[pos]  = k;
    slot_hits[pos] = h;
  endfunction

  function automatic void evict_cold_tail();
    int unsigned lim;
    lim = cap_r > SLOTS ? SLOTS : cap_r;
    while (cold_n > 0 && hot_n + cold_n >= lim) cold_n--;
  endfunction

  function automatic void demote_slot(int unsigned pos);
    logic [11:0] k;
    int unsigned h;
    if (pos >= hot_n) return;
    k = slot_key[pos];
    h = slot_hits[pos];
    slot_drop(pos);
    hot_n--;
    slot_put(hot_n + cold_n, k, h);
    cold_n++;
    evict_cold_tail();
  endfunction

  function automatic void promote_slot(int unsigned pos);
    logic [11:0] k;
    int unsigned h;
    k = slot_key[pos];
    h = slot_hits[pos];
    slot_drop(pos);
    cold_n--;
    slot_put(0, k, h);
    hot_n++;
    if (hot_n >= hot_cap_r) demote_slot(hot_n - 1);
  endfunction

  function automatic void decay_hot_zone();
    int unsigned p, j;
    p = pct_r > 100 ? 100 : pct_r;
    j = 0;
    while (j < hot_n) begin
      slot_hits[j] = slot_hits[j] * (100 - p) / 100;
      if (slot_hits[j] < promote_r) demote_slot(j);
      else j++;
    end
  endfunction

  // Work out the result of one access and advance the cache image.
  function automatic access_result_t access_cache(logic [11:0] k);
    access_result_t r;
    int unsigned    n, j;
    bit             found;
    n = hot_n + cold_n;
    found = 1'b0;
    for (j = 0; j < n; j++) begin
      if (slot_key[j] == k) begin
        found = 1'b1;
        break;
      end
    end
    if (found) begin
      if (hit_sum != 32'hFFFF_FFFF) hit_sum++;
      if (slot_hits[j] < HIT_LIMIT) slot_hits[j]++;
      if (j >= hot_n && slot_hits[j] >= promote_r) promote_slot(j);
    end else begin
      if (n >= SLOTS && cold_n > 0) begin
        cold_n--;
        n--;
      end
      if (n < SLOTS) begin
        slot_put(hot_n, k, 0);
        cold_n++;
        evict_cold_tail();
      end
    end
    access_n = (access_n + 1) & 16'hFFFF;
    if (access_n >= period_r) begin
      access_n = 0;
      decay_hot_zone();
    end
    r.hit = found;
    r.total_hits = hit_sum;
    return r;
  endfunction

  // Send one access request; idle about 35 percent of cycles unless quiet.
  task automatic send_key(logic [11:0] k);
    while (!quiet_send && $urandom_range(99) < 35) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(access_cache(k));
    @(negedge clk);
    in_tvalid <= 1'b0;
    // the block stays busy after an accept until it returns to idle
    @(negedge clk);
  endtask

  // Hold until every expected result has come, then let the block settle.
  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CAPACITY:      cap_r     = val & 16'h7F;
      REG_HOT_CAPACITY:  hot_cap_r = val & 16'h3F;
      REG_PROMOTE_HITS:  promote_r = val;
      REG_DECAY_PERIOD:  period_r  = val;
      REG_DECAY_PERCENT: pct_r     = val & 16'h7F;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(int unsigned cap, int unsigned hcap, int unsigned prom,
                            int unsigned per, int unsigned pct);
    drain();
    write_reg(REG_CAPACITY, 16'(cap));
    write_reg(REG_HOT_CAPACITY, 16'(hcap));
    write_reg(REG_PROMOTE_HITS, 16'(prom));
    write_reg(REG_DECAY_PERIOD, 16'(per));
    write_reg(REG_DECAY_PERCENT, 16'(pct));
  endtask

  // Directed: key extremes, repeated hits for promotion, small capacity.
  task automatic test_directed();
    send_key(12'h000);
    send_key(12'hFFF);
    send_key(12'h000);
    send_key(12'h000);
    send_key(12'h000);
    send_key(12'hFFF);
    send_key(12'hFFF);
    send_key(12'hAAA);
    send_key(12'h555);
    send_key(12'h555);
    // Capacity 2 with one hot slot: every promotion demotes straight back.
    set_config(2, 1, 1, 1, 0);
    send_key(12'h123);
    send_key(12'h123);
    send_key(12'h456);
    send_key(12'h123);
    // Full decay each access drops every hot entry.
    set_config(4, 3, 1, 1, 100);
    send_key(12'h010);
    send_key(12'h010);
    send_key(12'h020);
    send_key(12'h020);
  endtask

  // Fill at capacity 64 (63 live slots) with a large promote threshold so counts climb.
  task automatic test_full_table();
    set_config(64, 63, 65535, 65535, 0);
    quiet_send = 1'b1;
    for (int i = 0; i < 70; i++) send_key(12'h800 + i[11:0]);
    quiet_send = 1'b0;
    for (int i = 0; i < 60; i++) send_key(12'h800 + 12'($urandom_range(69)));
  endtask

  // Random accesses over a small key pool so hits, promotion and decay happen.
  task automatic test_random(int unsigned cnt, int unsigned pool);
    logic [11:0] base;
    base = 12'($urandom);
    for (int unsigned i = 0; i < cnt; i++) begin
      if ($urandom_range(9) == 0) send_key(12'($urandom));
      else send_key(base + 12'($urandom_range(pool - 1)));
    end
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    access_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit        = out_tdata[0];
      got.total_hits = out_tdata[32:1];
      if (expected_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit || got.total_hits !== want.total_hits) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: hit exp %b got %b, total exp %0d got %0d",
                     want.hit, got.hit, want.total_hits, got.total_hits);
        end
      end
    end
  end

  // Receiver stalls at random, except while quiet.
  always @(negedge clk) begin
    out_tready <= quiet_recv || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 2_000_000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    mismatches = 0;
    cycle_count = 0;
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    cap_r = 64; hot_cap_r = 16; promote_r = 2; period_r = 1000; pct_r = 50;
    hot_n = 0; cold_n = 0; access_n = 0; hit_sum = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_full_table();
    set_config(16, 6, 2, 7, 50);
    test_random(200, 24);
    set_config(10, 4, 3, 13, 30);
    quiet_send = 1'b1;
    quiet_recv = 1'b1;
    test_random(150, 16);
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    set_config(64, 16, 2, 1000, 50);
    test_random(200, 90);
    set_config(3, 2, 1, 5, 99);
    test_random(120, 6);
    set_config(40, 20, 4, 11, 127);
    test_random(150, 40);

    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
